// ----- src/eotm_pkg.sv -----
// Shared constants, codes and types for the eight-op tape machine core.
// No dependencies; every other file depends on this package.
package eotm_pkg;

   // Storage sizes
   localparam int unsigned TAPE_CELLS = 32768;
   localparam int unsigned PROG_DEPTH = 4096;

   // Widths
   localparam int unsigned DP_W   = $clog2(TAPE_CELLS);   // data pointer
   localparam int unsigned FILL_W = DP_W + 1;             // tape fill mark
   localparam int unsigned PA_W   = $clog2(PROG_DEPTH);   // program address
   localparam int unsigned PC_W   = PA_W + 1;             // program counter / length

   // Request kinds
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_STEP    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // Result status codes
   localparam logic [2:0] STAT_DONE    = 3'd0;
   localparam logic [2:0] STAT_OUT     = 3'd1;
   localparam logic [2:0] STAT_WAIT    = 3'd2;
   localparam logic [2:0] STAT_HALT    = 3'd3;
   localparam logic [2:0] STAT_UNDER   = 3'd4;
   localparam logic [2:0] STAT_UNMATCH = 3'd5;
   localparam logic [2:0] STAT_OVER    = 3'd6;

   // Instruction characters
   localparam logic [7:0] OP_RIGHT = 8'h3E;   // >
   localparam logic [7:0] OP_LEFT  = 8'h3C;   // <
   localparam logic [7:0] OP_INC   = 8'h2B;   // +
   localparam logic [7:0] OP_DEC   = 8'h2D;   // -
   localparam logic [7:0] OP_PUT   = 8'h2E;   // .
   localparam logic [7:0] OP_GET   = 8'h2C;   // ,
   localparam logic [7:0] OP_OPEN  = 8'h5B;   // [
   localparam logic [7:0] OP_CLOSE = 8'h5D;   // ]

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN_ADDR,
      S_SCAN_CHK,
      S_RESP
   } state_type;

endpackage

// ----- src/eotm_req_if.sv -----
// Request channel of the eight-op tape machine: valid/ready plus request fields.
// Depends on eotm_pkg for the program address width.
interface eotm_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [eotm_pkg::PA_W-1:0]   prog_addr;
   logic [7:0]                  prog_byte;
   logic                        prog_last;
   logic                        in_valid;
   logic [7:0]                  in_byte;
   logic                        in_eof;

   modport source (output valid, req_type, prog_addr, prog_byte, prog_last,
                   in_valid, in_byte, in_eof, input ready);
   modport sink   (input valid, req_type, prog_addr, prog_byte, prog_last,
                   in_valid, in_byte, in_eof, output ready);
endinterface

// ----- src/eotm_rsp_if.sv -----
// Result channel of the eight-op tape machine: valid/ready plus status fields.
// Depends on eotm_pkg for the program counter width.
interface eotm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  status;
   logic [7:0]                  out_byte;
   logic [eotm_pkg::PC_W-1:0]   pc_now;

   modport source (output valid, status, out_byte, pc_now, input ready);
   modport sink   (input valid, status, out_byte, pc_now, output ready);
endinterface

// ----- src/eight_op_tape_machine_core.sv -----
// Top level of the eight-op tape machine: sequencer, program store and tape.
// Depends on eotm_pkg, eotm_req_if and eotm_rsp_if.

// Each request gives one result. A load, a restart or a step that finds the machine
// halted goes from acceptance through the respond state to the result register; a
// simple instruction first passes the execute state (program and tape read, execute,
// respond). A taken bracket jump walks the scan address and scan check states for
// every program byte walked, since the scan reuses the single registered read port
// of the program store. The block takes no new request until the current one has
// reached the result register, so a stalled result side holds it in the respond
// state. The tape needs no clearing pass: a fill mark tracks how far cells have been
// written since restart and anything at or above it reads as zero.
module eight_op_tape_machine_core (
   input  logic              clock,
   input  logic              reset,
   eotm_req_if.sink          req_chan,
   eotm_rsp_if.source        rsp_chan
);
   import eotm_pkg::*;

   // Sequencer and architectural state
   state_type          state_ff, state_in;
   logic [DP_W-1:0]    dp_ff, dp_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [PC_W-1:0]    len_ff, len_in;
   logic               fault_ff, fault_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   // Request side fields held for the step
   logic               iv_ff, iv_in;
   logic [7:0]         ib_ff, ib_in;
   logic               eof_ff, eof_in;

   // Bracket scan
   logic [PC_W-1:0]    j_ff, j_in;
   logic [PC_W-1:0]    depth_ff, depth_in;
   logic               fwd_ff, fwd_in;

   // Pending result
   logic [2:0]         res_stat_ff, res_stat_in;
   logic [7:0]         res_byte_ff, res_byte_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_stat_ff, rsp_stat_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic [PC_W-1:0]    rsp_pc_ff, rsp_pc_in;

   // Memories
   logic [7:0]         prog_mem [PROG_DEPTH];
   logic [7:0]         tape_mem [TAPE_CELLS];
   logic [7:0]         prog_rd_ff;
   logic [7:0]         tape_rd_ff;
   logic [PA_W-1:0]    prog_raddr;
   logic               prog_we;
   logic               tape_we;
   logic [7:0]         tape_wd;

   // Shared decode
   logic               req_fire;
   logic               out_free;
   logic               halt_now;
   logic               dp_at_fill;
   logic [7:0]         cell_val;
   logic               scan_fwd_go;
   logic               scan_bwd_go;
   logic [PC_W-1:0]    depth_new;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign halt_now   = fault_ff || (pc_ff >= len_ff);
   assign dp_at_fill = ({1'b0, dp_ff} == fill_ff);
   assign cell_val   = dp_at_fill ? 8'd0 : tape_rd_ff;
   assign scan_fwd_go = (prog_rd_ff == OP_OPEN)  && (cell_val == 8'd0);
   assign scan_bwd_go = (prog_rd_ff == OP_CLOSE) && (cell_val != 8'd0);

   // Nesting depth after the byte just read in the scan
   always_comb begin
      depth_new = depth_ff;
      if (prog_rd_ff == (fwd_ff ? OP_OPEN : OP_CLOSE)) begin
         depth_new = depth_ff + PC_W'(1);
      end else if (prog_rd_ff == (fwd_ff ? OP_CLOSE : OP_OPEN)) begin
         depth_new = depth_ff - PC_W'(1);
      end
   end

   assign prog_raddr = (state_ff == S_SCAN_ADDR) ? j_ff[PA_W-1:0] : pc_ff[PA_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.req_type == REQ_STEP && !halt_now) begin
                  state_in = S_EXEC;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_EXEC: begin
            if (scan_fwd_go || (scan_bwd_go && pc_ff != '0)) begin
               state_in = S_SCAN_ADDR;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN_ADDR: begin
            if (fwd_ff && j_ff >= len_ff) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (depth_new == '0 || (!fwd_ff && j_ff == '0)) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SCAN_ADDR;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      dp_in       = dp_ff;
      pc_in       = pc_ff;
      len_in      = len_ff;
      fault_in    = fault_ff;
      fill_in     = fill_ff;
      iv_in       = iv_ff;
      ib_in       = ib_ff;
      eof_in      = eof_ff;
      j_in        = j_ff;
      depth_in    = depth_ff;
      fwd_in      = fwd_ff;
      res_stat_in = res_stat_ff;
      res_byte_in = res_byte_ff;
      prog_we     = 1'b0;
      tape_we     = 1'b0;
      tape_wd     = cell_val;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pc_in    = rsp_pc_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               iv_in       = req_chan.in_valid;
               ib_in       = req_chan.in_byte;
               eof_in      = req_chan.in_eof;
               res_stat_in = STAT_DONE;
               res_byte_in = 8'd0;
               case (req_chan.req_type)
                  REQ_LOAD: begin
                     if (PC_W'(req_chan.prog_addr) < PC_W'(PROG_DEPTH)) begin
                        prog_we = 1'b1;
                        if (req_chan.prog_last) begin
                           len_in = PC_W'(req_chan.prog_addr) + PC_W'(1);
                        end
                     end
                  end
                  REQ_STEP: begin
                     if (halt_now) begin
                        res_stat_in = STAT_HALT;
                     end
                  end
                  REQ_RESTART: begin
                     dp_in    = '0;
                     pc_in    = '0;
                     fault_in = 1'b0;
                     fill_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_EXEC: begin
            pc_in = pc_ff + PC_W'(1);
            case (prog_rd_ff)
               OP_RIGHT: begin
                  if (dp_ff == DP_W'(TAPE_CELLS - 1)) begin
                     pc_in       = pc_ff;
                     fault_in    = 1'b1;
                     res_stat_in = STAT_OVER;
                  end else begin
                     // leaving an uncharted cell: write it as zero to keep the mark
                     if (dp_at_fill) begin
                        tape_we = 1'b1;
                        tape_wd = 8'd0;
                        fill_in = fill_ff + FILL_W'(1);
                     end
                     dp_in = dp_ff + DP_W'(1);
                  end
               end
               OP_LEFT: begin
                  if (dp_ff == '0) begin
                     pc_in       = pc_ff;
                     fault_in    = 1'b1;
                     res_stat_in = STAT_UNDER;
                  end else begin
                     dp_in = dp_ff - DP_W'(1);
                  end
               end
               OP_INC, OP_DEC: begin
                  tape_we = 1'b1;
                  tape_wd = (prog_rd_ff == OP_INC) ? cell_val + 8'd1 : cell_val - 8'd1;
                  if (dp_at_fill) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
               OP_PUT: begin
                  res_stat_in = STAT_OUT;
                  res_byte_in = cell_val;
               end
               OP_GET: begin
                  if (iv_ff || eof_ff) begin
                     tape_we = 1'b1;
                     tape_wd = iv_ff ? ib_ff : 8'hFF;
                     if (dp_at_fill) begin
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end else begin
                     pc_in       = pc_ff;
                     res_stat_in = STAT_WAIT;
                  end
               end
               OP_OPEN: begin
                  if (scan_fwd_go) begin
                     pc_in    = pc_ff;
                     fwd_in   = 1'b1;
                     j_in     = pc_ff + PC_W'(1);
                     depth_in = PC_W'(1);
                  end
               end
               OP_CLOSE: begin
                  if (scan_bwd_go) begin
                     pc_in    = pc_ff;
                     fwd_in   = 1'b0;
                     j_in     = pc_ff - PC_W'(1);
                     depth_in = PC_W'(1);
                     if (pc_ff == '0) begin
                        fault_in    = 1'b1;
                        res_stat_in = STAT_UNMATCH;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_SCAN_ADDR: begin
            // forward scan ran off the end of the program
            if (fwd_ff && j_ff >= len_ff) begin
               fault_in    = 1'b1;
               res_stat_in = STAT_UNMATCH;
            end
         end
         S_SCAN_CHK: begin
            depth_in = depth_new;
            if (depth_new == '0) begin
               pc_in = j_ff + PC_W'(1);
            end else if (fwd_ff) begin
               j_in = j_ff + PC_W'(1);
            end else if (j_ff == '0) begin
               fault_in    = 1'b1;
               res_stat_in = STAT_UNMATCH;
            end else begin
               j_in = j_ff - PC_W'(1);
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_byte_in  = res_byte_ff;
               rsp_pc_in    = pc_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dp_ff        <= '0;
         pc_ff        <= '0;
         len_ff       <= '0;
         fault_ff     <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dp_ff        <= dp_in;
         pc_ff        <= pc_in;
         len_ff       <= len_in;
         fault_ff     <= fault_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      iv_ff       <= iv_in;
      ib_ff       <= ib_in;
      eof_ff      <= eof_in;
      j_ff        <= j_in;
      depth_ff    <= depth_in;
      fwd_ff      <= fwd_in;
      res_stat_ff <= res_stat_in;
      res_byte_ff <= res_byte_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_pc_ff   <= rsp_pc_in;
   end

   // Program store: load writes, registered read
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[req_chan.prog_addr] <= req_chan.prog_byte;
      end
      prog_rd_ff <= prog_mem[prog_raddr];
   end

   // Tape: read-modify-write at the data pointer
   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[dp_ff] <= tape_wd;
      end
      tape_rd_ff <= tape_mem[dp_ff];
   end

   // Ports
   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_stat_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.pc_now   = rsp_pc_ff;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for eight_op_tape_machine_core: table-driven directed requests,
// then random programs with random steps under random and long result-side stalls.
// Depends on eotm_pkg, eotm_req_if, eotm_rsp_if and the core itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import eotm_pkg::*;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam logic [7:0] NOP_CHAR    = 8'hFF;
   localparam int unsigned RANDOM_REQUESTS = 1850;
   localparam int unsigned IDLE_LIMIT      = 20000;
   localparam int unsigned LONG_HOLD       = 400;
   localparam int unsigned TAIL_CYCLES     = 40;

   typedef struct packed {
      logic [1:0]      kind;
      logic [PA_W-1:0] addr;
      logic [7:0]      pbyte;
      logic            last;
      logic            ivalid;
      logic [7:0]      ibyte;
      logic            ieof;
   } tape_request_type;

   typedef struct packed {
      logic [2:0]      status;
      logic [7:0]      out_byte;
      logic [PC_W-1:0] pc_now;
   } tape_status_type;

   typedef struct {
      tape_request_type req;
      bit               typed;
      tape_status_type  want;
   } stim_row_type;

   typedef logic [7:0] char_q_type[$];

   logic clock;
   logic reset;

   eotm_req_if req_bus ();
   eotm_rsp_if rsp_bus ();

   eight_op_tape_machine_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Machine image kept by the bench
   bit [7:0]    m_prog  [PROG_DEPTH];
   bit          m_known [PROG_DEPTH];
   bit [7:0]    m_tape  [TAPE_CELLS];
   int unsigned m_ptr;
   int unsigned m_pc;
   int unsigned m_len;
   bit          m_faulted;

   tape_status_type awaited_status[$];
   int unsigned     mismatches;
   int unsigned     requests_done;
   int unsigned     idle_cycles;
   int unsigned     rsp_hold_cycles;
   bit              src_idle_on;
   bit              snk_idle_on;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one request to the machine image and return the status it reports
   function automatic tape_status_type interp_step(input tape_request_type r);
      tape_status_type res;
      logic [7:0]      op;
      logic [7:0]      cur_val;
      int unsigned     nxt;
      int unsigned     depth;
      int unsigned     j;
      res.status   = STAT_DONE;
      res.out_byte = 8'h00;
      case (r.kind)
         REQ_LOAD: begin
            m_prog[r.addr]  = r.pbyte;
            m_known[r.addr] = 1'b1;
            if (r.last) m_len = r.addr + 1;
         end
         REQ_RESTART: begin
            foreach (m_tape[k]) m_tape[k] = 8'h00;
            m_ptr     = 0;
            m_pc      = 0;
            m_faulted = 1'b0;
         end
         REQ_STEP: begin
            if (m_faulted || m_pc >= m_len) begin
               res.status = STAT_HALT;
            end else begin
               op      = m_prog[m_pc];
               cur_val = m_tape[m_ptr];
               nxt     = m_pc + 1;
               case (op)
                  OP_RIGHT: begin
                     if (m_ptr + 1 >= TAPE_CELLS) res.status = STAT_OVER;
                     else m_ptr++;
                  end
                  OP_LEFT: begin
                     if (m_ptr == 0) res.status = STAT_UNDER;
                     else m_ptr--;
                  end
                  OP_INC: m_tape[m_ptr] = cur_val + 8'd1;
                  OP_DEC: m_tape[m_ptr] = cur_val - 8'd1;
                  OP_PUT: begin
                     res.status   = STAT_OUT;
                     res.out_byte = cur_val;
                  end
                  OP_GET: begin
                     // an offered byte wins over end of input
                     if (r.ivalid) m_tape[m_ptr] = r.ibyte;
                     else if (r.ieof) m_tape[m_ptr] = 8'hFF;
                     else res.status = STAT_WAIT;
                  end
                  OP_OPEN: begin
                     if (cur_val == 8'h00) begin
                        depth = 1;
                        j     = m_pc;
                        while (depth != 0 && res.status == STAT_DONE) begin
                           j++;
                           if (j >= m_len) res.status = STAT_UNMATCH;
                           else if (m_prog[j] == OP_OPEN) depth++;
                           else if (m_prog[j] == OP_CLOSE) depth--;
                        end
                        nxt = j + 1;
                     end
                  end
                  OP_CLOSE: begin
                     if (cur_val != 8'h00) begin
                        depth = 1;
                        j     = m_pc;
                        while (depth != 0 && res.status == STAT_DONE) begin
                           if (j == 0) begin
                              res.status = STAT_UNMATCH;
                           end else begin
                              j--;
                              if (m_prog[j] == OP_CLOSE) depth++;
                              else if (m_prog[j] == OP_OPEN) depth--;
                           end
                        end
                        nxt = j + 1;
                     end
                  end
                  default: ;
               endcase
               // a fault leaves pc on the offending instruction; a wait retries it
               if (res.status == STAT_OVER || res.status == STAT_UNDER ||
                   res.status == STAT_UNMATCH) begin
                  m_faulted = 1'b1;
               end else if (res.status != STAT_WAIT) begin
                  m_pc = nxt;
               end
            end
         end
         default: ;
      endcase
      res.pc_now = PC_W'(m_pc);
      return res;
   endfunction

   function automatic tape_request_type random_fields(input logic [1:0] kind);
      tape_request_type r;
      r.kind   = kind;
      r.addr   = PA_W'($urandom_range(0, PROG_DEPTH - 1));
      r.pbyte  = 8'($urandom_range(0, 255));
      r.last   = 1'($urandom_range(0, 1));
      r.ivalid = ($urandom_range(0, 3) != 0);
      r.ibyte  = 8'($urandom_range(0, 255));
      r.ieof   = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Mostly balanced programs; now and then a broken one with stray brackets
   function automatic char_q_type random_program();
      char_q_type  prog;
      int unsigned n;
      int unsigned open_cnt;
      bit          broken;
      n        = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 300)
                                              : $urandom_range(2, 40);
      broken   = ($urandom_range(0, 7) == 0);
      open_cnt = 0;
      if (!broken) begin
         prog.push_back(OP_RIGHT);
         prog.push_back(OP_INC);
      end
      for (int unsigned k = 0; k < n; k++) begin
         case ($urandom_range(0, 15))
            0, 1: begin
               prog.push_back(OP_OPEN);
               open_cnt++;
            end
            2, 3: begin
               if (open_cnt != 0 || broken) begin
                  prog.push_back(OP_CLOSE);
                  if (open_cnt != 0) open_cnt--;
               end else begin
                  prog.push_back(OP_INC);
               end
            end
            4, 5, 6: prog.push_back(OP_INC);
            7, 8:    prog.push_back(OP_DEC);
            9, 10:   prog.push_back(OP_RIGHT);
            11:      prog.push_back(OP_LEFT);
            12:      prog.push_back(OP_PUT);
            13:      prog.push_back(OP_GET);
            default: prog.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      if (!broken) begin
         while (open_cnt != 0) begin
            prog.push_back(OP_CLOSE);
            open_cnt--;
         end
      end
      return prog;
   endfunction

   function automatic stim_row_type row(input logic [1:0] kind, input int unsigned addr,
                                        input logic [7:0] pbyte, input bit last,
                                        input bit ivalid, input logic [7:0] ibyte,
                                        input bit ieof, input bit typed,
                                        input logic [2:0] st, input logic [7:0] ob,
                                        input int unsigned pc);
      stim_row_type s;
      s.req.kind      = kind;
      s.req.addr      = PA_W'(addr);
      s.req.pbyte     = pbyte;
      s.req.last      = last;
      s.req.ivalid    = ivalid;
      s.req.ibyte     = ibyte;
      s.req.ieof      = ieof;
      s.typed         = typed;
      s.want.status   = st;
      s.want.out_byte = ob;
      s.want.pc_now   = PC_W'(pc);
      return s;
   endfunction

   // Offer one request, wait for its acceptance and queue what it should report
   task automatic offer(input tape_request_type r, input bit typed,
                        input tape_status_type want, output tape_status_type got);
      int unsigned gap;
      gap = src_idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.req_type  <= r.kind;
      req_bus.prog_addr <= r.addr;
      req_bus.prog_byte <= r.pbyte;
      req_bus.prog_last <= r.last;
      req_bus.in_valid  <= r.ivalid;
      req_bus.in_byte   <= r.ibyte;
      req_bus.in_eof    <= r.ieof;
      req_bus.valid     <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      got = interp_step(r);
      awaited_status.push_back(typed ? want : got);
      if (r.kind != REQ_UNKNOWN) requests_done++;
   endtask

   // Stop offering and let every awaited status come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
   endtask

   // Stimulus
   initial begin
      stim_row_type     directed_rows[$];
      char_q_type       prog;
      tape_request_type r;
      tape_status_type  got;
      int unsigned      epoch;
      int unsigned      steps;

      reset             = 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= REQ_LOAD;
      req_bus.prog_addr <= '0;
      req_bus.prog_byte <= 8'h00;
      req_bus.prog_last <= 1'b0;
      req_bus.in_valid  <= 1'b0;
      req_bus.in_byte   <= 8'h00;
      req_bus.in_eof    <= 1'b0;
      m_ptr             = 0;
      m_pc              = 0;
      m_len             = 0;
      m_faulted         = 1'b0;
      mismatches        = 0;
      requests_done     = 0;
      rsp_hold_cycles   = 0;
      src_idle_on       = 1'b1;
      snk_idle_on       = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Program "-.,,.[-]" then a no-op byte and '<' that underflows at cell 0
      directed_rows = '{
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 1, STAT_HALT, 8'h00, 0),
         row(REQ_LOAD,    0,    OP_DEC,   0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    1,    OP_PUT,   0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    2,    OP_GET,   0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    3,    OP_GET,   0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    4,    OP_PUT,   0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    5,    OP_OPEN,  0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    6,    OP_DEC,   0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    7,    OP_CLOSE, 0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    8,    NOP_CHAR, 0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    9,    OP_LEFT,  1, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_LOAD,    4095, 8'h00,    0, 1, 8'hFF, 1, 1, STAT_DONE, 8'h00, 0),
         row(REQ_UNKNOWN, 4095, 8'hFF,    1, 1, 8'hFF, 1, 1, STAT_DONE, 8'h00, 0),
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 0, STAT_DONE, 8'h00, 0),
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 0, STAT_DONE, 8'h00, 0),
         // no byte and no end of input: the read waits
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 1, STAT_WAIT, 8'h00, 2),
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 1, 0, STAT_DONE, 8'h00, 0),
         row(REQ_STEP,    0,    8'h00,    0, 1, 8'h00, 1, 0, STAT_DONE, 8'h00, 0),
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 0, STAT_DONE, 8'h00, 0),
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 0, STAT_DONE, 8'h00, 0),
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 0, STAT_DONE, 8'h00, 0),
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 1, STAT_UNDER, 8'h00, 9),
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 1, STAT_HALT, 8'h00, 9),
         row(REQ_RESTART, 0,    8'h00,    0, 0, 8'h00, 0, 1, STAT_DONE, 8'h00, 0),
         row(REQ_STEP,    0,    8'h00,    0, 0, 8'h00, 0, 0, STAT_DONE, 8'h00, 0)
      };
      foreach (directed_rows[k]) begin
         offer(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want, got);
      end
      settle();

      // Random programs, each loaded in order and then stepped with random input
      epoch = 0;
      while (requests_done < RANDOM_REQUESTS) begin
         src_idle_on = ($urandom_range(0, 3) != 0);
         snk_idle_on = ($urandom_range(0, 3) != 0);
         if (epoch == 4) begin
            // result side holds off while requests keep coming
            src_idle_on     = 1'b0;
            rsp_hold_cycles = LONG_HOLD;
         end
         if ($urandom_range(0, 3) != 0) offer(random_fields(REQ_RESTART), 1'b0, '0, got);
         prog = random_program();
         foreach (prog[k]) begin
            r       = random_fields(REQ_LOAD);
            r.addr  = PA_W'(k);
            r.pbyte = prog[k];
            r.last  = (k == prog.size() - 1);
            offer(r, 1'b0, '0, got);
         end
         steps = $urandom_range(10, 60);
         repeat (steps) begin
            case ($urandom_range(0, 39))
               0: offer(random_fields(REQ_UNKNOWN), 1'b0, '0, got);
               1: offer(random_fields(REQ_RESTART), 1'b0, '0, got);
               2: begin
                  // stray write; a length mark only where everything below is loaded
                  r = random_fields(REQ_LOAD);
                  if ($urandom_range(0, 1) != 0) r.addr = PA_W'($urandom_range(0, 63));
                  for (int unsigned k = 0; k <= r.addr; k++) begin
                     if (!m_known[k]) r.last = 1'b0;
                  end
                  offer(r, 1'b0, '0, got);
               end
               default: offer(random_fields(REQ_STEP), 1'b0, '0, got);
            endcase
         end
         if (epoch == 4 || $urandom_range(0, 3) == 0) settle();
         epoch++;
      end

      // Drain and let the pipeline go quiet
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off on request, field checks
   initial begin
      tape_status_type want;
      int unsigned     gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = snk_idle_on ? $urandom_range(0, 13) : 0;
         if (rsp_hold_cycles != 0) begin
            gap             = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (awaited_status.size() == 0) begin
            $error("unexpected result: status %0d out_byte %0d pc_now %0d",
                   rsp_bus.status, rsp_bus.out_byte, rsp_bus.pc_now);
            mismatches++;
         end else begin
            want = awaited_status.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
               mismatches++;
            end
            if (rsp_bus.out_byte !== want.out_byte) begin
               $error("out_byte: expected %0d, actual %0d", want.out_byte, rsp_bus.out_byte);
               mismatches++;
            end
            if (rsp_bus.pc_now !== want.pc_now) begin
               $error("pc_now: expected %0d, actual %0d", want.pc_now, rsp_bus.pc_now);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule
